// ----- sv/rcfp_pkg.sv -----
// Shared types, character codes and conversion functions for the command frame parser.
package rcfp_pkg;

  // Only the leading bytes of the frame are ever inspected by the classifier.
  localparam int VIEW_BYTES = 14;
  localparam int POS_W      = $clog2(VIEW_BYTES);

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_H       = 8'h68;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [1:0] {
    CMD_HELLO  = 2'd0,
    CMD_COLOUR = 2'd1,
    CMD_BYE    = 2'd2
  } cmd_t;

  typedef logic [VIEW_BYTES-1:0][7:0] view_t;

  typedef struct packed {
    logic       hit;
    cmd_t       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } frame_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Number of characters taken before the first '%' (0..3).
  function automatic logic [1:0] take_count(input logic [2:0][7:0] f);
    logic [1:0] n;
    n = 2'd3;
    if (f[2] == CH_PERCENT) n = 2'd2;
    if (f[1] == CH_PERCENT) n = 2'd1;
    if (f[0] == CH_PERCENT) n = 2'd0;
    return n;
  endfunction

  // atoi over the first n characters, modulo 256.
  function automatic logic [7:0] atoi3(input logic [2:0][7:0] f, input logic [1:0] n);
    logic [7:0] acc;
    logic       neg;
    logic       in_num;
    logic       done;
    acc    = 8'd0;
    neg    = 1'b0;
    in_num = 1'b0;
    done   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n && !done) begin
        if (!in_num) begin
          if (is_ws(f[i])) begin
            in_num = 1'b0;
          end else if (f[i] == CH_PLUS || f[i] == CH_MINUS) begin
            neg    = (f[i] == CH_MINUS);
            in_num = 1'b1;
          end else if (is_digit(f[i])) begin
            acc    = f[i] - CH_ZERO;
            in_num = 1'b1;
          end else begin
            done = 1'b1;
          end
        end else if (is_digit(f[i])) begin
          acc = 8'((acc << 3) + (acc << 1) + (f[i] - CH_ZERO));
        end else begin
          done = 1'b1;
        end
      end
    end
    return neg ? 8'(8'd0 - acc) : acc;
  endfunction

  function automatic logic [2:0][7:0] pick3(input view_t v, input logic [POS_W-1:0] s);
    logic [2:0][7:0] f;
    for (int i = 0; i < 3; i++) begin
      f[i] = (int'(s) + i < VIEW_BYTES) ? v[POS_W'(int'(s) + i)] : 8'd0;
    end
    return f;
  endfunction

endpackage

// ----- sv/rcfp_if.sv -----
// Valid/ready channel interfaces for received bytes and parsed frames.
interface rcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] red_value;
  logic [7:0] green_value;
  logic [7:0] blue_value;

  modport source (output valid, output command, output red_value, output green_value,
                  output blue_value, input ready);
  modport sink   (input valid, input command, input red_value, input green_value,
                  input blue_value, output ready);
endinterface

// ----- sv/rcfp_frame_store.sv -----
// Frame buffer with saturating write index and end-of-frame pending flag.
module rcfp_frame_store #(
  parameter int FRAME_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [7:0]         wr_byte,
  input  logic               eval_done,
  output rcfp_pkg::view_t    view,
  output logic               pending
);
  import rcfp_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES + 1);

  view_t            buf_r, buf_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] idx_eff;
  logic             pend_r, pend_nxt;

  always_comb begin
    buf_nxt  = buf_r;
    idx_nxt  = idx_r;
    pend_nxt = pend_r && !eval_done;
    idx_eff  = (wr_byte == CH_DOLLAR) ? '0 : idx_r;
    if (wr_en) begin
      idx_nxt = idx_eff;
      if (idx_eff < IDX_W'(FRAME_BYTES)) begin
        // bytes past the inspected window only advance the index
        for (int i = 0; i < VIEW_BYTES; i++) begin
          if (idx_eff == IDX_W'(i)) buf_nxt[i] = wr_byte;
        end
        idx_nxt = idx_eff + 1'b1;
      end
      if (wr_byte == CH_HASH) pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      buf_r  <= buf_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign view    = buf_r;
  assign pending = pend_r;

endmodule

// ----- sv/rcfp_classify.sv -----
// Frame classification and colour field extraction from the buffer contents.
module rcfp_classify (
  input  rcfp_pkg::view_t    view,
  output rcfp_pkg::frame_res_t res
);
  import rcfp_pkg::*;

  logic [2:0][7:0]  f_r, f_g, f_b;
  logic [1:0]       n_r, n_g, n_b;
  logic [POS_W-1:0] last_r, last_g, gs, bs;
  logic             is_hello, is_colour, is_bye;

  always_comb begin
    f_r    = pick3(view, POS_W'(3));
    n_r    = take_count(f_r);
    last_r = (n_r == 2'd0) ? '0 : POS_W'(2 + int'(n_r));
    gs     = last_r + POS_W'(2);
    f_g    = pick3(view, gs);
    n_g    = take_count(f_g);
    last_g = (n_g == 2'd0) ? last_r : POS_W'(int'(gs) + int'(n_g) - 1);
    bs     = last_g + POS_W'(2);
    f_b    = pick3(view, bs);
    n_b    = take_count(f_b);

    is_hello  = view[1] == CH_H && view[2] == CH_I && view[3] == CH_HASH;
    is_colour = view[1] == CH_A && view[2] == CH_PERCENT;
    is_bye    = view[1] == CH_B;

    res       = '0;
    res.hit   = (view[0] == CH_DOLLAR) && (is_hello || is_colour || is_bye);
    if (is_hello) begin
      res.command = CMD_HELLO;
    end else if (is_colour) begin
      res.command = CMD_COLOUR;
      res.red     = atoi3(f_r, n_r);
      res.green   = atoi3(f_g, n_g);
      res.blue    = atoi3(f_b, n_b);
    end else begin
      res.command = CMD_BYE;
    end
  end

endmodule

// ----- sv/rgb_command_frame_parser.sv -----
// Top level: byte intake, frame store, classifier and result register.
//
//   channel | dir | beat payload                                   | accepted when
//   in_ch   | in  | rx_byte[7:0]                                   | valid && ready
//   out_ch  | out | command[1:0], red/green/blue_value[7:0]        | valid && ready
//
// One byte per cycle while in_ch.ready is high. A '#' byte is classified in the cycle
// after it is accepted; its frame, if any, is loaded when the result register is free.
// Reset (rst_n low, synchronous) clears the buffer, write index, pending flag and out valid.
// While a frame waits for a full result register, input is held off.
module rgb_command_frame_parser #(
  parameter int FRAME_BYTES = 16
) (
  input logic            clk,
  input logic            rst_n,
  rcfp_in_if.sink        in_ch,
  rcfp_out_if.source     out_ch
);
  import rcfp_pkg::*;

  view_t      view;
  logic       pending;
  frame_res_t res;
  logic       out_free;
  logic       eval_done;
  logic       in_acc;

  logic       out_valid_r, out_valid_nxt;
  cmd_t       cmd_r;
  logic [7:0] red_r, green_r, blue_r;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign eval_done = pending && (!res.hit || out_free);
  assign in_ch.ready = !pending || eval_done;
  assign in_acc    = in_ch.valid && in_ch.ready;

  rcfp_frame_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc),
    .wr_byte   (in_ch.rx_byte),
    .eval_done (eval_done),
    .view      (view),
    .pending   (pending)
  );

  rcfp_classify u_classify (
    .view (view),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (eval_done && res.hit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the payload only when a frame moves out of classification
  always_ff @(posedge clk) begin
    if (eval_done && res.hit) begin
      cmd_r   <= res.command;
      red_r   <= res.red;
      green_r <= res.green;
      blue_r  <= res.blue;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.command     = cmd_r;
  assign out_ch.red_value   = red_r;
  assign out_ch.green_value = green_r;
  assign out_ch.blue_value  = blue_r;

endmodule
